// ===== rtl/apm_pkg.sv =====
// Package with shared types, constants and helpers of the peak and mean meter.
package apm_pkg;

   localparam int RESET_RANGE_DEF  = 7;
   localparam int MAX_CAPTURES_DEF = 1280;
   localparam int MAX_SAMPLES_DEF  = 65536;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_SPC  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RC   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LTH  = 3'd4;

   localparam logic [3:0] CODE_MAX = 4'd13;
   localparam logic [3:0] CODE_MIN = 4'd2;

   typedef struct packed {
      logic signed [15:0] sample_a;
      logic signed [15:0] sample_b;
      logic signed [15:0] sample_c;
      logic signed [15:0] sample_d;
   } req_type;

   typedef struct packed {
      logic        [34:0] value_a;
      logic        [34:0] value_b;
      logic signed [35:0] value_c;
      logic        [34:0] value_d;
      logic        [3:0]  code_a;
      logic        [3:0]  code_b;
      logic        [3:0]  code_d;
      logic               rerun;
   } rsp_type;

   // Range multiplier by code; codes above 13 use the top entry.
   function automatic logic [11:0] range_mult(input logic [3:0] code);
      logic [11:0] m;
      case (code)
         4'd2:    m = 12'd1;
         4'd3:    m = 12'd2;
         4'd4:    m = 12'd4;
         4'd5:    m = 12'd10;
         4'd6:    m = 12'd20;
         4'd7:    m = 12'd40;
         4'd8:    m = 12'd100;
         4'd9:    m = 12'd200;
         4'd10:   m = 12'd400;
         4'd11:   m = 12'd1000;
         4'd12:   m = 12'd2000;
         4'd13, 4'd14, 4'd15: m = 12'd4000;
         default: m = 12'd0;
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/apm_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module apm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [49:0] dividend,
   input  logic [27:0] divisor,
   output logic        done,
   output logic [49:0] quotient
);
   import apm_pkg::*;

   logic [49:0] quot_ff, quot_in;
   logic [27:0] rem_ff, rem_in;
   logic [27:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [28:0] trial;

   // One shift-subtract step per cycle.
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[49]} - {1'b0, dsr_ff};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[28]) begin
            rem_in = trial[27:0];
         end else begin
            rem_in = {rem_ff[26:0], quot_ff[49]};
         end
         quot_in = {quot_ff[48:0], ~trial[28]};
         cnt_in  = cnt_ff + 6'd1;
         if (cnt_ff == 6'd49) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== rtl/autorange_peak_mean_meter_core.sv =====
// Top level of the autoranging peak and mean meter.
// Usage:
//   req_ carries one four-channel sample per transaction. Within a capture
//   the peaks of |a| and |b| are tracked; over its first half c (signed) and
//   |d| are summed. Only the last sample of the last capture causes a
//   rsp_ transaction.
//   At that point the block drops req_ready and runs its end-of-measurement
//   sequence: four divisions on one shared 50-bit restoring divider, one
//   quotient bit a cycle, then autoranging of the three range codes and
//   four products on one shared multiplier, one a cycle; a rerun skips the
//   products.
//   The result then waits in an output register until rsp_ready; a new
//   sample is taken only after the result has left.
//   rsp_rerun set means a range code changed and the values are zero.
//   csr_ writes take effect on the next sample; write only while idle.
//   Reset (synchronous, active high) restores the register defaults,
//   clears all sums and counts and sets the three range codes to
//   RESET_RANGE. No clearing pass is needed.
module autorange_peak_mean_meter_core #(
   parameter int RESET_RANGE  = apm_pkg::RESET_RANGE_DEF,
   parameter int MAX_CAPTURES = apm_pkg::MAX_CAPTURES_DEF,
   parameter int MAX_SAMPLES  = apm_pkg::MAX_SAMPLES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  apm_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output apm_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [apm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [apm_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import apm_pkg::*;

   localparam logic [3:0] RST_CODE = 4'(RESET_RANGE);
   localparam logic [16:0] MAXS = 17'(MAX_SAMPLES);
   localparam logic [12:0] MAXC = 13'(MAX_CAPTURES);

   localparam logic [2:0] ST_ACC  = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_WAIT = 3'd2;
   localparam logic [2:0] ST_RNG  = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   // Configuration registers.
   logic [16:0] spc_ff;
   logic [10:0] caps_ff;
   logic [3:0]  rc_ff;
   logic [15:0] hth_ff, lth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spc_ff  <= 17'd1024;
         caps_ff <= 11'd1;
         rc_ff   <= 4'd7;
         hth_ff  <= 16'd30000;
         lth_ff  <= 16'd600;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPC:  spc_ff  <= csr_wdata;
            CSR_CAPS: caps_ff <= csr_wdata[10:0];
            CSR_RC:   rc_ff   <= csr_wdata[3:0];
            CSR_HTH:  hth_ff  <= csr_wdata[15:0];
            CSR_LTH:  lth_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Effective lengths after clamping.
   logic [16:0] spc_eff;
   logic [12:0] caps_eff;
   logic [15:0] half;
   always_comb begin
      spc_eff = spc_ff;
      if (spc_eff < 17'd2) spc_eff = 17'd2;
      if (spc_eff > MAXS) spc_eff = MAXS;
      caps_eff = {2'b0, caps_ff};
      if (caps_eff == 13'd0) caps_eff = 13'd1;
      if (caps_eff > MAXC) caps_eff = MAXC;
      half = spc_eff[16:1];
   end

   logic [2:0]  state_ff, state_in;
   logic [15:0] scnt_ff;
   logic [12:0] ccnt_ff;
   logic [15:0] pk_a_ff, pk_b_ff;
   logic [28:0] psum_a_ff, psum_b_ff;
   logic signed [41:0] tot_c_ff;
   logic [40:0] tot_d_ff;
   logic [3:0]  code_ff [3];
   logic [2:0]  step_ff;
   logic [41:0] mean_ff [4];
   logic [28:0] n_ff;
   logic [3:0]  chg_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   logic [15:0] abs_a, abs_b, abs_d;
   logic        req_fire, last_s, last_c;

   assign abs_a = req_data.sample_a[15] ? 16'(-req_data.sample_a) : req_data.sample_a;
   assign abs_b = req_data.sample_b[15] ? 16'(-req_data.sample_b) : req_data.sample_b;
   assign abs_d = req_data.sample_d[15] ? 16'(-req_data.sample_d) : req_data.sample_d;
   assign req_ready = (state_ff == ST_ACC) && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign last_s    = ({1'b0, scnt_ff} + 17'd1) >= spc_eff;
   assign last_c    = ({1'b0, ccnt_ff} + 13'd1) >= caps_eff;

   // Shared divider.
   logic        div_start, div_done;
   logic [49:0] div_dvd, div_q;
   logic [27:0] div_dsr;
   logic [41:0] mag_c;
   assign mag_c = tot_c_ff[41] ? 42'(-tot_c_ff) : 42'(tot_c_ff);

   always_comb begin
      div_dvd = '0;
      div_dsr = {15'b0, caps_eff};
      case (step_ff)
         3'd0: div_dvd = {13'b0, psum_a_ff, 8'b0};
         3'd1: div_dvd = {13'b0, psum_b_ff, 8'b0};
         3'd2: begin
            div_dvd = {mag_c, 8'b0};
            div_dsr = n_ff[27:0];
         end
         default: begin
            div_dvd = {1'b0, tot_d_ff, 8'b0};
            div_dsr = n_ff[27:0];
         end
      endcase
   end
   assign div_start = (state_ff == ST_DIV);

   apm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quotient (div_q)
   );

   // Shared multiplier: one mean times one range multiplier per cycle.
   logic [41:0] mul_a;
   logic [11:0] mul_m;
   logic [53:0] mul_p;
   always_comb begin
      mul_a = mean_ff[step_ff[1:0]];
      case (step_ff)
         3'd0:    mul_m = range_mult(code_ff[0]);
         3'd1:    mul_m = range_mult(code_ff[1]);
         3'd2:    mul_m = range_mult(rc_ff);
         default: mul_m = range_mult(code_ff[2]);
      endcase
      mul_p = mul_a * mul_m;
   end

   // Autorange decision for one channel.
   logic [3:0] rng_code, rng_next;
   logic [41:0] rng_mean;
   logic       rng_chg;
   always_comb begin
      case (step_ff)
         3'd0:    begin rng_code = code_ff[0]; rng_mean = mean_ff[0]; end
         3'd1:    begin rng_code = code_ff[1]; rng_mean = mean_ff[1]; end
         default: begin rng_code = code_ff[2]; rng_mean = mean_ff[3]; end
      endcase
      rng_next = rng_code;
      rng_chg  = 1'b0;
      if (rng_mean > {18'b0, hth_ff, 8'b0}) begin
         if (rng_code < CODE_MAX) begin
            rng_next = rng_code + 4'd1;
            rng_chg  = 1'b1;
         end
      end else if (rng_mean < {18'b0, lth_ff, 8'b0}) begin
         if (rng_code > CODE_MIN) begin
            rng_next = rng_code - 4'd1;
            rng_chg  = 1'b1;
         end
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACC:  if (req_fire && last_s && last_c) state_in = ST_DIV;
         ST_DIV:  state_in = ST_WAIT;
         ST_WAIT: if (div_done) state_in = (step_ff == 3'd3) ? ST_RNG : ST_DIV;
         ST_RNG:  if (step_ff == 3'd2) state_in = (chg_ff != 4'd0 || rng_chg) ?
                                                  ST_OUT : ST_MUL;
         ST_MUL:  if (step_ff == 3'd3) state_in = ST_OUT;
         ST_OUT:  state_in = ST_ACC;
         default: state_in = ST_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         scnt_ff      <= '0;
         ccnt_ff      <= '0;
         pk_a_ff      <= '0;
         pk_b_ff      <= '0;
         psum_a_ff    <= '0;
         psum_b_ff    <= '0;
         tot_c_ff     <= '0;
         tot_d_ff     <= '0;
         code_ff[0]   <= RST_CODE;
         code_ff[1]   <= RST_CODE;
         code_ff[2]   <= RST_CODE;
         step_ff      <= '0;
         chg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_ACC: if (req_fire) begin
               if (scnt_ff < half) begin
                  tot_c_ff <= tot_c_ff + 42'(req_data.sample_c);
                  tot_d_ff <= tot_d_ff + 41'(abs_d);
               end
               if (!last_s) begin
                  scnt_ff <= scnt_ff + 16'd1;
                  if (abs_a > pk_a_ff) pk_a_ff <= abs_a;
                  if (abs_b > pk_b_ff) pk_b_ff <= abs_b;
               end else begin
                  scnt_ff   <= '0;
                  pk_a_ff   <= '0;
                  pk_b_ff   <= '0;
                  psum_a_ff <= psum_a_ff + 29'((abs_a > pk_a_ff) ? abs_a : pk_a_ff);
                  psum_b_ff <= psum_b_ff + 29'((abs_b > pk_b_ff) ? abs_b : pk_b_ff);
                  if (!last_c) ccnt_ff <= ccnt_ff + 13'd1;
                  else begin
                     step_ff <= '0;
                     chg_ff  <= '0;
                  end
               end
            end
            ST_WAIT: if (div_done) begin
               mean_ff[step_ff[1:0]] <= div_q[41:0];
               step_ff <= (step_ff == 3'd3) ? 3'd0 : step_ff + 3'd1;
            end
            ST_RNG: begin
               chg_ff[step_ff[1:0]] <= rng_chg;
               case (step_ff)
                  3'd0:    code_ff[0] <= rng_next;
                  3'd1:    code_ff[1] <= rng_next;
                  default: code_ff[2] <= rng_next;
               endcase
               step_ff <= (step_ff == 3'd2) ? 3'd0 : step_ff + 3'd1;
               if (step_ff == 3'd2) rsp_ff <= '0;
            end
            ST_MUL: begin
               case (step_ff)
                  3'd0: rsp_ff.value_a <= mul_p[34:0];
                  3'd1: rsp_ff.value_b <= mul_p[34:0];
                  3'd2: rsp_ff.value_c <= tot_c_ff[41] ? 36'(-mul_p) : mul_p[35:0];
                  default: rsp_ff.value_d <= mul_p[34:0];
               endcase
               step_ff <= step_ff + 3'd1;
            end
            ST_OUT: begin
               rsp_ff.code_a <= code_ff[0];
               rsp_ff.code_b <= code_ff[1];
               rsp_ff.code_d <= code_ff[2];
               rsp_ff.rerun  <= (chg_ff != 4'd0);
               rsp_valid_ff  <= 1'b1;
               ccnt_ff   <= '0;
               psum_a_ff <= '0;
               psum_b_ff <= '0;
               tot_c_ff  <= '0;
               tot_d_ff  <= '0;
            end
            default: ;
         endcase
      end
      if (state_ff == ST_DIV && step_ff == 3'd0) n_ff <= 29'(half * caps_eff);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // No sample is taken while a result or the end sequence is pending.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ACC || rsp_valid_ff) |-> !req_ready)
      else $error("sample taken while busy");
   // The divider finishes only while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_WAIT)
      else $error("divider done out of sequence");
   // A result appears only after the output step.
   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result without output step");
`endif

endmodule

// ===== dv/autorange_peak_mean_meter_core_test.sv =====
// Self-checking testbench for the autoranging peak and mean meter core.
module autorange_peak_mean_meter_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import apm_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int ITEM_TARGET = 900;

   // Predicts each measurement result and keeps the results still owed by the block.
   class meter_scoreboard;
      bit [16:0]       spc_reg;
      bit [10:0]       caps_reg;
      bit [3:0]        range_c_reg;
      bit [15:0]       high_reg;
      bit [15:0]       low_reg;
      int unsigned     sample_cnt;
      int unsigned     capture_cnt;
      longint unsigned peak_a;
      longint unsigned peak_b;
      longint unsigned peak_sum_a;
      longint unsigned peak_sum_b;
      longint unsigned abs_sum_d;
      longint          sum_c;
      bit [3:0]        codes [3];
      rsp_type         pending_results [$];
      int              errors;

      function new();
         spc_reg     = 17'd1024;
         caps_reg    = 11'd1;
         range_c_reg = 4'd7;
         high_reg    = 16'd30000;
         low_reg     = 16'd600;
         errors      = 0;
         clear_sums();
         foreach (codes[k]) codes[k] = 4'(RESET_RANGE_DEF);
      endfunction

      function void clear_sums();
         sample_cnt  = 0;
         capture_cnt = 0;
         peak_a      = 0;
         peak_b      = 0;
         peak_sum_a  = 0;
         peak_sum_b  = 0;
         abs_sum_d   = 0;
         sum_c       = 0;
      endfunction

      function void write_reg(bit [CSR_IDX_W-1:0] idx, bit [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_SPC:  spc_reg     = value;
            CSR_CAPS: caps_reg    = value[10:0];
            CSR_RC:   range_c_reg = value[3:0];
            CSR_HTH:  high_reg    = value[15:0];
            CSR_LTH:  low_reg     = value[15:0];
            default: ;
         endcase
      endfunction

      // Multiplier of a range code; codes past the table use the top entry.
      function longint unsigned scale_of(bit [3:0] code);
         longint unsigned table_vals [14] = '{0, 0, 1, 2, 4, 10, 20, 40, 100, 200, 400,
                                              1000, 2000, 4000};
         return table_vals[(code > 13) ? 13 : code];
      endfunction

      // Steps one range code by the Q8 mean; returns whether it moved.
      function bit step_code(inout bit [3:0] code, input longint unsigned mean_q8);
         if (mean_q8 > (longint'(high_reg) << 8)) begin
            if (code < 13) begin
               code++;
               return 1'b1;
            end
         end else if (mean_q8 < (longint'(low_reg) << 8)) begin
            if (code > 2) begin
               code--;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      // Accounts for one accepted sample transaction.
      function void note_sample(req_type s);
         longint unsigned spc;
         longint unsigned caps;
         longint unsigned half;
         longint          a, b, c, d;
         longint unsigned n, mean_a, mean_b, mean_d, mag_c, mean_c;
         longint          vc;
         bit              moved;
         bit [3:0]        cd;
         rsp_type         r;
         spc  = spc_reg;
         caps = caps_reg;
         if (spc < 2) spc = 2;
         if (spc > MAX_SAMPLES_DEF) spc = MAX_SAMPLES_DEF;
         if (caps < 1) caps = 1;
         if (caps > MAX_CAPTURES_DEF) caps = MAX_CAPTURES_DEF;
         half = spc / 2;
         a = longint'($signed(s.sample_a));
         b = longint'($signed(s.sample_b));
         c = longint'($signed(s.sample_c));
         d = longint'($signed(s.sample_d));
         if (a < 0) a = -a;
         if (b < 0) b = -b;
         if (d < 0) d = -d;
         if (a > peak_a) peak_a = a;
         if (b > peak_b) peak_b = b;
         if (sample_cnt < half) begin
            sum_c     += c;
            abs_sum_d += d;
         end
         if (sample_cnt + 1 < spc) begin
            sample_cnt++;
            return;
         end
         // Capture done: fold the peaks in.
         peak_sum_a += peak_a;
         peak_sum_b += peak_b;
         peak_a     = 0;
         peak_b     = 0;
         sample_cnt = 0;
         if (capture_cnt + 1 < caps) begin
            capture_cnt++;
            return;
         end
         // Measurement done: means, autoranging and scaled values.
         n      = half * caps;
         mean_a = (peak_sum_a << 8) / caps;
         mean_b = (peak_sum_b << 8) / caps;
         mean_d = (abs_sum_d << 8) / n;
         mag_c  = (sum_c < 0) ? longint'(-sum_c) : longint'(sum_c);
         mean_c = (mag_c << 8) / n;
         moved  = 1'b0;
         for (int k = 0; k < 3; k++) begin
            cd = codes[k];
            moved |= step_code(cd, (k == 0) ? mean_a : (k == 1) ? mean_b : mean_d);
            codes[k] = cd;
         end
         r = '0;
         if (!moved) begin
            vc = longint'(mean_c * scale_of(range_c_reg));
            if (sum_c < 0) vc = -vc;
            r.value_a = 35'(mean_a * scale_of(codes[0]));
            r.value_b = 35'(mean_b * scale_of(codes[1]));
            r.value_c = 36'(vc);
            r.value_d = 35'(mean_d * scale_of(codes[2]));
         end
         r.code_a = codes[0];
         r.code_b = codes[1];
         r.code_d = codes[2];
         r.rerun  = moved;
         pending_results.push_back(r);
         clear_sums();
      endfunction

      function void compare_field(string name, longint e, longint g);
         if (e != g) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, g);
         end
      endfunction

      // Checks one accepted result transaction against the oldest prediction.
      function void check_result(rsp_type got);
         rsp_type e;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none actual %h", $time, got);
            return;
         end
         e = pending_results.pop_front();
         compare_field("value_a", e.value_a, got.value_a);
         compare_field("value_b", e.value_b, got.value_b);
         compare_field("value_c", longint'(e.value_c), longint'(got.value_c));
         compare_field("value_d", e.value_d, got.value_d);
         compare_field("code_a", e.code_a, got.code_a);
         compare_field("code_b", e.code_b, got.code_b);
         compare_field("code_d", e.code_d, got.code_d);
         compare_field("rerun", e.rerun, got.rerun);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   meter_scoreboard sb = new();
   int              cycles;
   int              samples_sent;
   bit              sender_no_gaps;
   bit              receiver_no_stalls;

   autorange_peak_mean_meter_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Clock generation.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   // Result receiver with random stalls.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = receiver_no_stalls ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'($urandom_range(0, 255)) - 16'd128;
         default: return 16'($urandom);
      endcase
   endfunction

   // Sends one sample transaction after an optional gap.
   task automatic send_sample(input req_type s);
      int gap;
      gap = sender_no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(s);
      samples_sent++;
   endtask

   // Holds the sender until every owed result has arrived and the block is quiet.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   // Writes all five registers back to back while the block is idle.
   task automatic write_regs(input logic [16:0] spc, input logic [10:0] caps,
                             input logic [3:0] rc, input logic [15:0] hth,
                             input logic [15:0] lth);
      logic [CSR_DATA_W-1:0] vals [5];
      vals = '{spc, 17'(caps), 17'(rc), 17'(hth), 17'(lth)};
      for (int k = 0; k < 5; k++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(k);
         csr_wdata <= vals[k];
         @(posedge clock);
         sb.write_reg(CSR_IDX_W'(k), vals[k]);
      end
      csr_we <= 1'b0;
   endtask

   // Main sequence.
   initial begin
      req_type     s;
      logic [16:0] spc;
      logic [10:0] caps;
      logic [15:0] hth, lth;
      int          count;
      cycles             = 0;
      samples_sent       = 0;
      sender_no_gaps     = 1'b0;
      receiver_no_stalls = 1'b0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_data           = '0;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Short captures at extremes; thresholds of zero drive the codes up toward the cap.
      write_regs(17'd0, 11'd0, 4'd15, 16'd0, 16'd0);
      send_sample('{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
      send_sample('{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
      send_sample('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
      send_sample('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
      for (int k = 0; k < 8; k++) send_sample('{16'h8000, 16'h8000, 16'h8000, 16'h8000});
      wait_drained();

      // Full thresholds step the codes down toward the floor.
      write_regs(17'd1, 11'd1, 4'd0, 16'hFFFF, 16'hFFFF);
      for (int k = 0; k < 14; k++) send_sample('{16'h0100, 16'hFF00, 16'h0001, 16'h0002});
      wait_drained();

      // Random phases over many register settings.
      while (samples_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 11))
            0:       spc = 17'h1FFFF;
            1:       spc = 17'h10000;
            2:       spc = 17'($urandom);
            3:       spc = 17'($urandom_range(0, 1));
            default: spc = 17'($urandom_range(2, 8));
         endcase
         case ($urandom_range(0, 9))
            0:       caps = 11'h7FF;
            1:       caps = 11'd0;
            default: caps = 11'($urandom_range(1, 4));
         endcase
         case ($urandom_range(0, 3))
            0: begin hth = 16'd0;    lth = 16'd0;    end
            1: begin hth = 16'hFFFF; lth = 16'hFFFF; end
            2: begin hth = 16'hFFFF; lth = 16'd0;    end
            default: begin
               hth = 16'($urandom_range(0, 32768));
               lth = 16'($urandom_range(0, 32768));
            end
         endcase
         sender_no_gaps     = ($urandom_range(0, 3) == 0);
         receiver_no_stalls = ($urandom_range(0, 3) == 0);
         write_regs(spc, caps, 4'($urandom), hth, lth);
         count = $urandom_range(10, 60);
         for (int k = 0; k < count; k++) begin
            s.sample_a = pick_sample();
            s.sample_b = pick_sample();
            s.sample_c = pick_sample();
            s.sample_d = pick_sample();
            send_sample(s);
         end
         wait_drained();
      end

      // Let late results appear, then report.
      repeat (300) @(posedge clock);
      if (sb.pending_results.size() != 0) begin
         sb.errors++;
         $display("%0t: results missing, expected %0d actual 0", $time,
                  sb.pending_results.size());
      end
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/apm_pkg.sv
rtl/apm_div.sv
rtl/autorange_peak_mean_meter_core.sv
dv/autorange_peak_mean_meter_core_test.sv
